// ----- rtl/rgbbd_pkg.sv -----
// rgbbd_pkg: shared types, register indexes and channel helpers for the
// RGB555 box decimator. No dependencies.
package rgbbd_pkg;

  typedef enum logic [1:0] {
    CFG_ZOOM_MODE     = 2'd0,
    CFG_SRC_ROW_PITCH = 2'd1,
    CFG_OUT_COLUMNS   = 2'd2,
    CFG_OUT_ROWS      = 2'd3
  } cfg_index_t;

  localparam int CH_W   = 5;
  localparam int SUM_W  = 7;
  localparam int GSUM_W = 3 * SUM_W;

  localparam logic [1:0]  ZOOM_RST    = 2'd0;
  localparam logic [12:0] PITCH_RST   = 13'd640;
  localparam logic [10:0] COLUMNS_RST = 11'd320;
  localparam logic [11:0] ROWS_RST    = 12'd240;

  localparam logic [12:0] PITCH_MAX = 13'd4096;
  localparam logic [12:0] ROW_SAT   = 13'd8191;

  typedef logic [GSUM_W-1:0] gsum_t;

  typedef struct packed {
    gsum_t      gsum;
    logic       add_row;
    logic [1:0] sh;
    logic       row_end;
    logic       frame_end;
  } s2_t;

  // blue -> bits 0-6, green -> bits 7-13, red -> bits 14-20
  function automatic gsum_t pack_channels(input logic [15:0] pix);
    return {2'b00, pix[15:11], 2'b00, pix[10:6], 2'b00, pix[4:0]};
  endfunction

endpackage

// ----- rtl/rgbbd_ram.sv -----
// rgbbd_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rgbbd_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rgb555_box_decimator_top.sv -----
// rgb555_box_decimator_top: RGB555 box-filter downsampler (2x1, 4x1, 2x2, 4x2).
// Depends on rgbbd_pkg and rgbbd_ram.
//
// Accepts one source pixel per clock and produces at most one averaged pixel per
// transaction. If the output register is free, a result appears there on the clock
// edge after the edge that accepts its last source pixel. Throughput is one pixel
// per cycle, set by the counter/group-sum update and the line store,
// which takes at most one write (even row of a 2-row mode) or one read (odd row)
// per pixel. The line store holds one 21-bit channel-sum entry per output column
// and needs no clearing; input is back-pressured only when both result stages are
// full and out_ready is low.
module rgb555_box_decimator_top #(
  parameter int MAX_OUT_COLUMNS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pixel,
  input  logic        in_first_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel,
  output logic        out_row_end,
  output logic        out_frame_end
);

  localparam int AW = $clog2(MAX_OUT_COLUMNS);
  localparam logic [12:0]   MAX_COLS = 13'(MAX_OUT_COLUMNS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_OUT_COLUMNS - 1);

  logic [1:0]  zoom_mode_r;
  logic [12:0] src_row_pitch_r;
  logic [10:0] out_columns_r;
  logic [11:0] out_rows_r;

  logic [11:0]         col_r, col_nxt;
  logic [12:0]         row_r, row_nxt;
  rgbbd_pkg::gsum_t    gsum_r, gsum_nxt;
  logic                s2_v_r, s2_v_nxt;
  rgbbd_pkg::s2_t      s2_r, s2_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_pixel_r, out_pixel_nxt;
  logic                out_row_end_r, out_frame_end_r;

  logic                acc, s2_adv;
  logic                quad, two_row;
  logic [12:0]         pitch, pitch_div, cols13, col_limit, used_rows, c_inc, group13;
  logic [10:0]         cols, group;
  logic [11:0]         c;
  logic [12:0]         r;
  rgbbd_pkg::gsum_t    gs_cur, gs_new;
  logic                in_range, phase_zero, phase_last, grp_end, emit;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  rgbbd_pkg::gsum_t    ram_rdata;
  logic [7:0]          tot [3];
  logic [7:0]          quo [3];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_mode_r     <= rgbbd_pkg::ZOOM_RST;
      src_row_pitch_r <= rgbbd_pkg::PITCH_RST;
      out_columns_r   <= rgbbd_pkg::COLUMNS_RST;
      out_rows_r      <= rgbbd_pkg::ROWS_RST;
    end else if (cfg_we) begin
      case (rgbbd_pkg::cfg_index_t'(cfg_index))
        rgbbd_pkg::CFG_ZOOM_MODE:     zoom_mode_r     <= cfg_wdata[1:0];
        rgbbd_pkg::CFG_SRC_ROW_PITCH: src_row_pitch_r <= cfg_wdata;
        rgbbd_pkg::CFG_OUT_COLUMNS:   out_columns_r   <= cfg_wdata[10:0];
        rgbbd_pkg::CFG_OUT_ROWS:      out_rows_r      <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // stage 1: counters, group sum, line store access
  always_comb begin
    quad    = zoom_mode_r[0];
    two_row = zoom_mode_r[1];

    if (src_row_pitch_r == 13'd0) begin
      pitch = 13'd1;
    end else if (src_row_pitch_r > rgbbd_pkg::PITCH_MAX) begin
      pitch = rgbbd_pkg::PITCH_MAX;
    end else begin
      pitch = src_row_pitch_r;
    end
    pitch_div = quad ? (pitch >> 2) : (pitch >> 1);

    cols13 = {2'b00, out_columns_r};
    if (cols13 > MAX_COLS) begin
      cols13 = MAX_COLS;
    end
    if (cols13 > pitch_div) begin
      cols13 = pitch_div;
    end
    cols      = cols13[10:0];
    col_limit = quad ? {cols, 2'b00} : {1'b0, cols, 1'b0};
    used_rows = two_row ? {out_rows_r, 1'b0} : {1'b0, out_rows_r};

    c      = in_first_of_frame ? 12'd0 : col_r;
    r      = in_first_of_frame ? 13'd0 : row_r;
    gs_cur = in_first_of_frame ? '0 : gsum_r;

    in_range   = (r < used_rows) && ({1'b0, c} < col_limit);
    phase_zero = quad ? (c[1:0] == 2'b00) : !c[0];
    phase_last = quad ? (c[1:0] == 2'b11) : c[0];
    group      = quad ? {1'b0, c[11:2]} : c[11:1];
    gs_new     = (phase_zero ? '0 : gs_cur) + rgbbd_pkg::pack_channels(in_pixel);
    grp_end    = in_range && phase_last;
    emit       = grp_end && (!two_row || r[0]);

    group13  = {2'b00, group};
    ram_addr = (group13 >= MAX_COLS) ? LAST_ADDR : group13[AW-1:0];

    in_ready = !s2_v_r || !out_valid_r || out_ready;
    acc      = in_valid && in_ready;
    s2_adv   = s2_v_r && (!out_valid_r || out_ready);
    ram_we   = acc && grp_end && two_row && !r[0];
    ram_re   = acc && grp_end && two_row && r[0];

    gsum_nxt = in_range ? gs_new : gs_cur;
    c_inc    = {1'b0, c} + 13'd1;
    if (c_inc >= pitch) begin
      col_nxt = 12'd0;
      row_nxt = (r < rgbbd_pkg::ROW_SAT) ? r + 13'd1 : r;
    end else begin
      col_nxt = c_inc[11:0];
      row_nxt = r;
    end

    s2_nxt.gsum      = gs_new;
    s2_nxt.add_row   = two_row;
    s2_nxt.sh        = (quad ? 2'd2 : 2'd1) + {1'b0, two_row};
    s2_nxt.row_end   = (group == cols - 11'd1);
    s2_nxt.frame_end = s2_nxt.row_end && (r == used_rows - 13'd1);

    if (acc) begin
      s2_v_nxt = emit;
    end else if (s2_adv) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
  end

  rgbbd_ram #(
    .WIDTH (rgbbd_pkg::GSUM_W),
    .DEPTH (MAX_OUT_COLUMNS)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (gs_new),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // stage 2: vertical add, average, pack
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot[k] = {1'b0, s2_r.gsum[k*rgbbd_pkg::SUM_W +: rgbbd_pkg::SUM_W]}
             + (s2_r.add_row ? {1'b0, ram_rdata[k*rgbbd_pkg::SUM_W +: rgbbd_pkg::SUM_W]}
                             : 8'd0);
      quo[k] = tot[k] >> s2_r.sh;
    end
    out_pixel_nxt = {quo[2][4:0], quo[1][4:0], 1'b0, quo[0][4:0]};
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      gsum_r      <= '0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        gsum_r <= gsum_nxt;
      end
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      s2_r <= s2_nxt;
    end
    if (s2_adv) begin
      out_pixel_r     <= out_pixel_nxt;
      out_row_end_r   <= s2_r.row_end;
      out_frame_end_r <= s2_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store read and write in one cycle");

  assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (s2_v_r && s2_r.add_row))
    else $error("line store read without a two-row result in stage 2");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_adv) |=> s2_v_r)
    else $error("stalled stage 2 lost");

endmodule
